// File: hw/rtl/dmpi_pkg.sv
// ----------------------------------------------------------------------------
// dmpi_pkg - shared types and constants of the dual motor PI controller
// Sequencer states, multiplier operand selects, the control word from the
// sequencer and the configuration register set.
// ----------------------------------------------------------------------------
package dmpi_pkg;

    // multiplier operand width: holds |count*720| and the reciprocal of 334
    localparam int MUL_W  = 27;
    localparam int PROD_W = 2 * MUL_W;

    // rpm = count * 12 * 60 / 334
    localparam int SAMPLE_RATE        = 12;
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int COUNTS_PER_TURN    = 334;
    localparam int RPM_SCALE          = SAMPLE_RATE * SECONDS_PER_MINUTE;

    // divide by 334 as multiply by ceil(2^34/334) then shift; exact for
    // dividends below 2^25
    localparam int      RECIP_SHIFT = 34;
    localparam longint  RECIP_VALUE = ((64'd1 << RECIP_SHIFT) + COUNTS_PER_TURN - 1)
                                      / COUNTS_PER_TURN;
    localparam logic [MUL_W-1:0] RECIP_MULT = RECIP_VALUE[MUL_W-1:0];
    localparam logic [MUL_W-1:0] RPM_MULT   = RPM_SCALE[MUL_W-1:0];

    localparam int LIMIT_RESET = 4095;

    localparam logic signed [15:0] KP0_RESET   = 16'sd500;
    localparam logic signed [15:0] KI0_RESET   = 16'sd200;
    localparam logic signed [15:0] KP1_RESET   = 16'sd500;
    localparam logic signed [15:0] KI1_RESET   = 16'sd900;
    localparam logic signed [15:0] DMIN_RESET  = -16'(LIMIT_RESET);
    localparam logic signed [15:0] DMAX_RESET  = 16'(LIMIT_RESET);

    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_KP0  = 3'd0,
        REG_KI0  = 3'd1,
        REG_KP1  = 3'd2,
        REG_KI1  = 3'd3,
        REG_DMIN = 3'd4,
        REG_DMAX = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [15:0] kp0;
        logic signed [15:0] ki0;
        logic signed [15:0] kp1;
        logic signed [15:0] ki1;
        logic signed [15:0] drive_min;
        logic signed [15:0] drive_max;
    } gains_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_RECIP,
        ST_SPEED,
        ST_ERROR,
        ST_INTEG,
        ST_DRIVE
    } state_t;

    typedef enum logic [1:0] {
        MUL_SCALE,
        MUL_RECIP,
        MUL_KI,
        MUL_KP
    } mul_sel_t;

    // flags of the word on the input channel, seen by the sequencer
    typedef struct packed {
        logic chan_ok;
        logic new_sample;
        logic count_error;
    } item_flags_t;

    typedef struct packed {
        logic     load_item;
        logic     speed_clear;
        logic     sign_load;
        logic     speed_load;
        logic     err_load;
        logic     integ_load;
        logic     drive_load;
        logic     mul_en;
        mul_sel_t mul_sel;
    } ctrl_t;

endpackage

// File: hw/rtl/dmpi_cfg.sv
// ----------------------------------------------------------------------------
// dmpi_cfg - configuration register file
// Gains and drive limits, written one register per word.
// ----------------------------------------------------------------------------
module dmpi_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               wr_en,
    input  logic [dmpi_pkg::REG_IDX_W-1:0]     wr_index,
    input  logic [15:0]                        wr_data,
    output dmpi_pkg::gains_t                   gains
);

    dmpi_pkg::gains_t gains_reg;
    dmpi_pkg::gains_t gains_next;

    always_comb begin
        gains_next = gains_reg;
        if (wr_en) begin
            case (dmpi_pkg::reg_index_t'(wr_index))
                dmpi_pkg::REG_KP0:  gains_next.kp0       = wr_data;
                dmpi_pkg::REG_KI0:  gains_next.ki0       = wr_data;
                dmpi_pkg::REG_KP1:  gains_next.kp1       = wr_data;
                dmpi_pkg::REG_KI1:  gains_next.ki1       = wr_data;
                dmpi_pkg::REG_DMIN: gains_next.drive_min = wr_data;
                dmpi_pkg::REG_DMAX: gains_next.drive_max = wr_data;
                default:            gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg.kp0       <= dmpi_pkg::KP0_RESET;
            gains_reg.ki0       <= dmpi_pkg::KI0_RESET;
            gains_reg.kp1       <= dmpi_pkg::KP1_RESET;
            gains_reg.ki1       <= dmpi_pkg::KI1_RESET;
            gains_reg.drive_min <= dmpi_pkg::DMIN_RESET;
            gains_reg.drive_max <= dmpi_pkg::DMAX_RESET;
        end else begin
            gains_reg <= gains_next;
        end
    end

    assign gains = gains_reg;

endmodule

// File: hw/rtl/dmpi_mul.sv
// ----------------------------------------------------------------------------
// dmpi_mul - shared signed multiplier
// One signed product per cycle while en is high, registered; used for the rpm
// scale, the reciprocal divide and both PI gains.
// ----------------------------------------------------------------------------
module dmpi_mul (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [dmpi_pkg::MUL_W-1:0]   op_a,
    input  logic signed [dmpi_pkg::MUL_W-1:0]   op_b,
    output logic signed [dmpi_pkg::PROD_W-1:0]  prod
);

    logic signed [dmpi_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

// File: hw/rtl/dmpi_seq.sv
// ----------------------------------------------------------------------------
// dmpi_seq - control sequencer
// Steps one tick through speed scaling (good samples only), error, integrator
// and drive, issuing at most one multiply per step.
// ----------------------------------------------------------------------------
module dmpi_seq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  dmpi_pkg::item_flags_t  in_flags,
    input  logic                   out_stall,
    output logic                   in_ready,
    output dmpi_pkg::ctrl_t        ctrl
);

    dmpi_pkg::state_t state_reg;
    dmpi_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dmpi_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctrl       = '0;
        ctrl.mul_sel = dmpi_pkg::MUL_SCALE;
        case (state_reg)
            dmpi_pkg::ST_IDLE: begin
                // no word taken while reset is held
                in_ready = aresetn;
                if (in_valid && aresetn) begin
                    ctrl.load_item   = 1'b1;
                    ctrl.speed_clear = in_flags.chan_ok & in_flags.new_sample
                                       & in_flags.count_error;
                    if (!in_flags.chan_ok) begin
                        state_next = dmpi_pkg::ST_IDLE;
                    end else if (in_flags.new_sample && !in_flags.count_error) begin
                        state_next = dmpi_pkg::ST_SCALE;
                    end else begin
                        state_next = dmpi_pkg::ST_ERROR;
                    end
                end
            end
            dmpi_pkg::ST_SCALE: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = dmpi_pkg::MUL_SCALE;
                state_next   = dmpi_pkg::ST_RECIP;
            end
            dmpi_pkg::ST_RECIP: begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_sel   = dmpi_pkg::MUL_RECIP;
                ctrl.sign_load = 1'b1;
                state_next     = dmpi_pkg::ST_SPEED;
            end
            dmpi_pkg::ST_SPEED: begin
                ctrl.speed_load = 1'b1;
                state_next      = dmpi_pkg::ST_ERROR;
            end
            dmpi_pkg::ST_ERROR: begin
                ctrl.mul_en   = 1'b1;
                ctrl.mul_sel  = dmpi_pkg::MUL_KI;
                ctrl.err_load = 1'b1;
                state_next    = dmpi_pkg::ST_INTEG;
            end
            dmpi_pkg::ST_INTEG: begin
                ctrl.mul_en     = 1'b1;
                ctrl.mul_sel    = dmpi_pkg::MUL_KP;
                ctrl.integ_load = 1'b1;
                state_next      = dmpi_pkg::ST_DRIVE;
            end
            dmpi_pkg::ST_DRIVE: begin
                // product is held while the output word waits
                if (!out_stall) begin
                    ctrl.drive_load = 1'b1;
                    state_next      = dmpi_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dmpi_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/dual_motor_pi_speed_controller.sv
// ----------------------------------------------------------------------------
// dual_motor_pi_speed_controller - two-channel PI speed loop with clamp
//
//  channel | dir | handshake              | word
//  --------+-----+------------------------+-----------------------------------
//  s_      | in  | s_tvalid / s_tready    | tdata: target, count; tuser: flags
//  m_      | out | m_tvalid / m_tready    | tdata: fwd, rev compare; tuser
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_wdata (gain/limit)
//
// A tick with a good encoder sample steps through scale, reciprocal and speed
// before error, integrator and drive; other ticks start at error. Input words
// are taken only in idle. A tick for a channel not below CHANNEL_COUNT
// gives no result. aresetn (synchronous) clears integrators, speeds,
// fault lights and restores default gains and limits. A stalled m_ side holds
// the finished word; the next input word is still taken, and its drive step
// waits until the output register frees. s_tready and cfg_ready stay low
// while aresetn is low; cfg_ready is high otherwise.
// ----------------------------------------------------------------------------
module dual_motor_pi_speed_controller #(
    parameter int FRACTION_SHIFT = 16,
    parameter int CHANNEL_COUNT  = 2
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input ticks
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,   // target_speed, latched_count
    input  logic [2:0]                         s_tuser,   // channel, new_sample, count_error
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,   // forward_compare, reverse_compare, pad
    output logic [1:0]                         m_tuser,   // out_channel, fault_light
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dmpi_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                        cfg_wdata
);

    localparam int MW = dmpi_pkg::MUL_W;

    dmpi_pkg::gains_t      gains;
    dmpi_pkg::ctrl_t       ctrl;
    dmpi_pkg::item_flags_t in_flags;

    // ---- latched tick ----
    logic               ch_reg;
    logic signed [15:0] target_reg;
    logic signed [15:0] count_reg;

    // ---- per-channel loop state ----
    logic [31:0]        integ_reg [CHANNEL_COUNT];
    logic signed [15:0] speed_reg [CHANNEL_COUNT];
    logic               fault_reg [CHANNEL_COUNT];

    // ---- working registers ----
    logic signed [15:0] err_reg;
    logic               neg_reg;

    // ---- output word ----
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [31:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    logic signed [MW-1:0]               mul_a;
    logic signed [MW-1:0]               mul_b;
    logic signed [dmpi_pkg::PROD_W-1:0] prod;

    logic signed [15:0] kp_cur;
    logic signed [15:0] ki_cur;
    logic signed [15:0] err_comb;
    logic signed [MW-1:0] scaled;
    logic signed [MW-1:0] scaled_abs;
    logic [15:0]        quot;
    logic signed [15:0] speed_new;
    logic signed [31:0] prod32;
    logic signed [31:0] iterm;
    logic signed [31:0] pi_sum;
    logic signed [31:0] pi_shift;
    logic signed [15:0] drive_raw;
    logic signed [15:0] drive;
    logic [14:0]        fwd_cmp;
    logic [15:0]        rev_cmp;

    // ---- configuration ----
    assign cfg_ready = aresetn;

    dmpi_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_wdata),
        .gains    (gains)
    );

    // ---- sequencer ----
    assign in_flags.chan_ok     = ({31'd0, s_tuser[0]} < CHANNEL_COUNT);
    assign in_flags.new_sample  = s_tuser[1];
    assign in_flags.count_error = s_tuser[2];

    dmpi_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_flags  (in_flags),
        .out_stall (m_tvalid_reg & ~m_tready),
        .in_ready  (s_tready),
        .ctrl      (ctrl)
    );

    // ---- operand selection for the shared multiplier ----
    assign kp_cur = ch_reg ? gains.kp1 : gains.kp0;
    assign ki_cur = ch_reg ? gains.ki1 : gains.ki0;

    // speed error, wrapped to 16 bits; channel 1 runs with reversed sign
    assign err_comb = ch_reg ? (speed_reg[ch_reg] - target_reg)
                             : (target_reg - speed_reg[ch_reg]);

    assign scaled     = prod[MW-1:0];
    assign scaled_abs = scaled[MW-1] ? -scaled : scaled;

    always_comb begin
        case (ctrl.mul_sel)
            dmpi_pkg::MUL_SCALE: begin
                mul_a = MW'(count_reg);
                mul_b = dmpi_pkg::RPM_MULT;
            end
            dmpi_pkg::MUL_RECIP: begin
                mul_a = scaled_abs;
                mul_b = dmpi_pkg::RECIP_MULT;
            end
            dmpi_pkg::MUL_KI: begin
                mul_a = MW'(err_comb);
                mul_b = MW'(ki_cur);
            end
            dmpi_pkg::MUL_KP: begin
                mul_a = MW'(err_reg);
                mul_b = MW'(kp_cur);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    dmpi_mul u_mul (
        .aclk (aclk),
        .en   (ctrl.mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // ---- speed: quotient truncated toward zero, then to 16 bits ----
    assign quot      = prod[dmpi_pkg::RECIP_SHIFT +: 16];
    assign speed_new = neg_reg ? -$signed(quot) : $signed(quot);

    // ---- PI law ----
    assign prod32    = prod[31:0];
    assign iterm     = prod32 >>> FRACTION_SHIFT;
    assign pi_sum    = prod32 + $signed(integ_reg[ch_reg]);
    assign pi_shift  = pi_sum >>> FRACTION_SHIFT;
    assign drive_raw = pi_shift[15:0];

    // lower bound tested first; inverted limits give the minimum below it, else the maximum
    always_comb begin
        if (drive_raw < gains.drive_min) begin
            drive = gains.drive_min;
        end else if (drive_raw > gains.drive_max) begin
            drive = gains.drive_max;
        end else begin
            drive = drive_raw;
        end
    end

    assign fwd_cmp = (drive > 16'sd0) ? drive[14:0] : 15'd0;
    assign rev_cmp = (drive < 16'sd0) ? 16'(-drive) : 16'd0;

    // ---- registers ----
    always_ff @(posedge aclk) begin
        if (ctrl.load_item) begin
            ch_reg     <= s_tuser[0];
            target_reg <= s_tdata[15:0];
            count_reg  <= s_tdata[31:16];
        end
        if (ctrl.sign_load) begin
            neg_reg <= scaled[MW-1];
        end
        if (ctrl.err_load) begin
            err_reg <= err_comb;
        end
        if (ctrl.drive_load) begin
            m_tdata_reg <= {1'b0, rev_cmp, fwd_cmp};
            m_tuser_reg <= {fault_reg[ch_reg], ch_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                integ_reg[i] <= '0;
                speed_reg[i] <= '0;
                fault_reg[i] <= 1'b0;
            end
        end else begin
            // encoder fault: speed forced to zero on acceptance
            if (ctrl.speed_clear) begin
                speed_reg[s_tuser[0]] <= '0;
                fault_reg[s_tuser[0]] <= 1'b1;
            end
            if (ctrl.speed_load) begin
                speed_reg[ch_reg] <= speed_new;
                fault_reg[ch_reg] <= 1'b0;
            end
            if (ctrl.integ_load) begin
                integ_reg[ch_reg] <= integ_reg[ch_reg] + 32'(iterm);
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (ctrl.drive_load) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
